// ===== design/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg: shared types for the 17.14 fixed-point ALU
// Transaction payloads, opcode names and the sideband carried down the
// divider chain.
// ----------------------------------------------------------------------------
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_TRUNC   = 4'd0,
    OP_ROUND   = 4'd1,
    OP_INT2FIX = 4'd2,
    OP_FRAC    = 4'd3,
    OP_ADD_FI  = 4'd4,
    OP_ADD_FF  = 4'd5,
    OP_SUB_FI  = 4'd6,
    OP_SUB_FF  = 4'd7,
    OP_MUL_FI  = 4'd8,
    OP_MUL_FF  = 4'd9,
    OP_DIV_FI  = 4'd10,
    OP_DIV_FF  = 4'd11
  } fpa_op_e;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               divide_by_zero;
  } fpa_out_t;

  // Travels alongside the quotient through every divider cell.
  typedef struct packed {
    logic        is_div;
    logic        neg;
    logic        dz;
    logic [31:0] res;
  } fpa_side_t;

endpackage

// ===== design/fixed_point_17_14_alu_core.sv =====
// ----------------------------------------------------------------------------
// fixed_point_17_14_alu_core: pipelined signed 17.14 fixed-point ALU
// Trunc, round, conversion, add, subtract, multiply and divide on 32-bit
// operands, one result transaction per input transaction.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-----------------------
//  input   | in        | in_valid_i / in_ready_o | in_data_i  (fpa_in_t)
//  output  | out       | out_valid_o / out_ready_i | out_data_o (fpa_out_t)
//
// One transaction is accepted every cycle unless the pipeline holds. The
// pipeline is one preparation stage, 32 + FRACTION_BITS divider cells (one
// quotient bit each) and the output register. Every operation takes the
// full chain so results leave in order. When the output register is full
// and not taken, the whole pipeline holds and in_ready_o drops. Reset
// clears only the valid bits of each stage.
//
module fixed_point_17_14_alu_core #(
  parameter int FRACTION_BITS = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fpa_pkg::fpa_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fpa_pkg::fpa_out_t out_data_o
);
  import fpa_pkg::*;

  // The dividend magnitude needs 32 + FRACTION_BITS bits, one cell per bit.
  localparam int DW = 32 + FRACTION_BITS;

  logic adv;

  logic          valid_s [DW+1];
  fpa_side_t     side_s  [DW+1];
  logic [31:0]   rem_s   [DW+1];
  logic [DW-1:0] nq_s    [DW+1];
  logic [31:0]   den_s   [DW+1];

  logic        out_valid_q;
  fpa_out_t    out_d, out_q;
  logic [31:0] quot;

  // The whole chain advances together whenever the output register can
  // take a new value.
  assign adv        = out_ready_i || !out_valid_q;
  assign in_ready_o = adv;

  fpa_prep #(
    .FRACTION_BITS(FRACTION_BITS),
    .DW           (DW)
  ) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(in_valid_i),
    .data_i (in_data_i),
    .valid_o(valid_s[0]),
    .side_o (side_s[0]),
    .nq_o   (nq_s[0]),
    .den_o  (den_s[0])
  );

  // The partial remainder starts at zero at the head of the chain.
  assign rem_s[0] = '0;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    fpa_div_cell #(
      .DW(DW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(valid_s[i]),
      .side_i (side_s[i]),
      .rem_i  (rem_s[i]),
      .nq_i   (nq_s[i]),
      .den_i  (den_s[i]),
      .valid_o(valid_s[i+1]),
      .side_o (side_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .nq_o   (nq_s[i+1]),
      .den_o  (den_s[i+1])
    );
  end

  // Only the low 32 bits of the quotient survive, so the sign is applied
  // on those alone. A zero divisor forces the result to zero.
  always_comb begin
    quot = side_s[DW].neg ? (~nq_s[DW][31:0] + 1'b1) : nq_s[DW][31:0];
    out_d.divide_by_zero = side_s[DW].dz;
    if (!side_s[DW].is_div) begin
      out_d.result_value = side_s[DW].res;
    end else if (side_s[DW].dz) begin
      out_d.result_value = '0;
    end else begin
      out_d.result_value = quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= valid_s[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/fpa_prep.sv =====
// ----------------------------------------------------------------------------
// fpa_prep: operand preparation stage
// Computes all non-divide results and the divider's magnitudes and signs,
// and registers them at the head of the divider chain.
// ----------------------------------------------------------------------------
module fpa_prep #(
  parameter int FRACTION_BITS = 14,
  parameter int DW            = 32 + FRACTION_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  fpa_pkg::fpa_in_t  data_i,
  output logic              valid_o,
  output fpa_pkg::fpa_side_t side_o,
  output logic [DW-1:0]     nq_o,
  output logic [31:0]       den_o
);
  import fpa_pkg::*;

  localparam logic [31:0] HALF = 32'd1 << (FRACTION_BITS - 1);

  logic signed [31:0] a, b;
  logic signed [63:0] prod;
  logic [31:0]        a_sh, b_sh, rnd, den;
  logic [DW-1:0]      num;
  logic               valid_q;
  fpa_side_t          side_d, side_q;
  logic [DW-1:0]      nq_d, nq_q;
  logic [31:0]        den_d, den_q;

  always_comb begin
    a      = data_i.operand_a;
    b      = data_i.operand_b;
    prod   = a * b;
    a_sh   = {a[31-FRACTION_BITS:0], {FRACTION_BITS{1'b0}}};
    b_sh   = {b[31-FRACTION_BITS:0], {FRACTION_BITS{1'b0}}};
    rnd    = a[31] ? (a - HALF) : (a + HALF);
    side_d = '0;
    num    = '0;
    den    = '0;
    case (fpa_op_e'(data_i.cmd))
      OP_TRUNC:   side_d.res = 32'($signed(a) >>> FRACTION_BITS);
      OP_ROUND:   side_d.res = 32'($signed(rnd) >>> FRACTION_BITS);
      OP_INT2FIX: side_d.res = a_sh;
      OP_ADD_FI:  side_d.res = a + b_sh;
      OP_ADD_FF:  side_d.res = a + b;
      OP_SUB_FI:  side_d.res = a - b_sh;
      OP_SUB_FF:  side_d.res = a - b;
      OP_MUL_FI:  side_d.res = prod[31:0];
      OP_MUL_FF:  side_d.res = prod[FRACTION_BITS+31:FRACTION_BITS];
      OP_FRAC: begin
        side_d.is_div = 1'b1;
        num = {a_sh, {FRACTION_BITS{1'b0}}};
        den = b_sh;
      end
      OP_DIV_FI: begin
        side_d.is_div = 1'b1;
        num = {{(DW-32){a[31]}}, a};
        den = b;
      end
      OP_DIV_FF: begin
        side_d.is_div = 1'b1;
        num = {a, {FRACTION_BITS{1'b0}}};
        den = b;
      end
      default: side_d.res = '0;
    endcase
    side_d.dz  = side_d.is_div && (den == '0);
    side_d.neg = num[DW-1] ^ den[31];
    nq_d       = num[DW-1] ? (~num + 1'b1) : num;
    den_d      = den[31] ? (~den + 1'b1) : den;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      nq_q   <= nq_d;
      den_q  <= den_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign nq_o    = nq_q;
  assign den_o   = den_q;

endmodule

// ===== design/fpa_div_cell.sv =====
// ----------------------------------------------------------------------------
// fpa_div_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, tries the divisor and
// shifts the quotient bit in; hands the result to the next cell.
// ----------------------------------------------------------------------------
module fpa_div_cell #(
  parameter int DW = 46
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  fpa_pkg::fpa_side_t side_i,
  input  logic [31:0]        rem_i,
  input  logic [DW-1:0]      nq_i,
  input  logic [31:0]        den_i,
  output logic               valid_o,
  output fpa_pkg::fpa_side_t side_o,
  output logic [31:0]        rem_o,
  output logic [DW-1:0]      nq_o,
  output logic [31:0]        den_o
);
  import fpa_pkg::*;

  logic [32:0]   trial, diff;
  logic          ge;
  logic          valid_q;
  fpa_side_t     side_q;
  logic [31:0]   rem_d, rem_q, den_q;
  logic [DW-1:0] nq_d, nq_q;

  always_comb begin
    trial = {rem_i, nq_i[DW-1]};
    diff  = trial - {1'b0, den_i};
    ge    = trial >= {1'b0, den_i};
    rem_d = ge ? diff[31:0] : trial[31:0];
    nq_d  = {nq_i[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      rem_q  <= rem_d;
      nq_q   <= nq_d;
      den_q  <= den_i;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign den_o   = den_q;

endmodule

// ===== tb/fixed_point_17_14_alu_checker.sv =====
// ----------------------------------------------------------------------------
// fixed_point_17_14_alu_checker: result scoreboard for the 17.14 ALU
// Watches both channels, works out the result of every accepted input
// transaction and compares it with the result transactions in order.
// ----------------------------------------------------------------------------
module fixed_point_17_14_alu_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  fpa_pkg::fpa_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  fpa_pkg::fpa_out_t out_data_i,
  output int                error_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  localparam int FB = 14;

  fpa_out_t awaited_results[$];

  // Signed 64-bit quotient truncated toward zero, wrapping modulo 2^64.
  function automatic logic [63:0] quot64(logic [63:0] num, logic [63:0] den);
    logic [63:0] mn;
    logic [63:0] md;
    logic [63:0] q;
    mn = num[63] ? -num : num;
    md = den[63] ? -den : den;
    q  = mn / md;
    return (num[63] != den[63]) ? -q : q;
  endfunction

  function automatic fpa_out_t alu_result(fpa_in_t t);
    fpa_out_t    r;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] d;
    logic [31:0] half;
    logic [63:0] p;
    a = t.operand_a;
    b = t.operand_b;
    half = 32'd1 << (FB - 1);
    r = '0;
    case (t.cmd)
      OP_TRUNC:   r.result_value = $signed(a) >>> FB;
      OP_ROUND:   r.result_value = a[31] ? $signed(a - half) >>> FB : $signed(a + half) >>> FB;
      OP_INT2FIX: r.result_value = a << FB;
      OP_FRAC: begin
        d = b << FB;
        if (d == 0) r.divide_by_zero = 1'b1;
        else begin
          p = {{32{a[31-FB]}}, a << FB};
          r.result_value = quot64(p << FB, {{32{d[31]}}, d});
        end
      end
      OP_ADD_FI:  r.result_value = a + (b << FB);
      OP_ADD_FF:  r.result_value = a + b;
      OP_SUB_FI:  r.result_value = a - (b << FB);
      OP_SUB_FF:  r.result_value = a - b;
      OP_MUL_FI:  r.result_value = a * b;
      OP_MUL_FF: begin
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        r.result_value = $signed(p) >>> FB;
      end
      OP_DIV_FI: begin
        if (b == 0) r.divide_by_zero = 1'b1;
        else r.result_value = quot64({{32{a[31]}}, a}, {{32{b[31]}}, b});
      end
      OP_DIV_FF: begin
        if (b == 0) r.divide_by_zero = 1'b1;
        else r.result_value = quot64({{32{a[31]}}, a} << FB, {{32{b[31]}}, b});
      end
      default: ;
    endcase
    return r;
  endfunction

  initial error_count_o = 0;
  initial pending_o = 0;

  always @(posedge clk_i) begin
    fpa_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) awaited_results.push_back(alu_result(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result transaction %h", out_data_i);
          error_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (want.result_value !== out_data_i.result_value) begin
            $error("result_value expected %h got %h", want.result_value,
                   out_data_i.result_value);
            error_count_o++;
          end
          if (want.divide_by_zero !== out_data_i.divide_by_zero) begin
            $error("divide_by_zero expected %b got %b", want.divide_by_zero,
                   out_data_i.divide_by_zero);
            error_count_o++;
          end
        end
      end
    end
    pending_o = awaited_results.size();
  end
endmodule

// ===== tb/fixed_point_17_14_alu_core_test.sv =====
// ----------------------------------------------------------------------------
// fixed_point_17_14_alu_core_test: top level of the ALU testbench
// Drives directed and random operations through the ALU with random idling
// on both channels and a long output stall, then reports the verdict.
// ----------------------------------------------------------------------------
module fixed_point_17_14_alu_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  // The pipeline is FRACTION_BITS + 34 deep.
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 200000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  fpa_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  fpa_out_t out_data_o;
  int       error_count;
  int       pending;

  // Idling percentages for each phase; the receiver process reads recv_idle_pct.
  int       send_idle_pct = 13;
  int       recv_idle_pct = 85;
  bit       long_hold = 1'b0;
  int       cycle_count = 0;

  always #6 clk_i = ~clk_i;

  fixed_point_17_14_alu_core DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  fixed_point_17_14_alu_checker checker_inst (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .error_count_o(error_count), .pending_o(pending)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fixed_point_17_14_alu_core_test: done, errors");
      $finish;
    end
  end

  // Receiver: ready is redrawn each falling edge, except during a long hold,
  // when it stays low so that the pipeline fills and in_ready_o drops.
  always @(negedge clk_i) begin
    if (long_hold) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    long_hold = 1'b0;
    wait (cycle_count == 2000);
    @(negedge clk_i);
    long_hold = 1'b1;
    repeat (300) @(negedge clk_i);
    long_hold = 1'b0;
  end

  // Operands that stress the edges: zero, one, minus one, the extremes and
  // values around the fraction boundary.
  function automatic logic [31:0] edge_operand();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      5: return 32'h0000_4000;
      6: return 32'h0000_2000;
      7: return 32'hFFFF_C000 | $urandom_range(3);
      8: return $urandom_range(65535) << 14;
      default: return $urandom();
    endcase
  endfunction

  // One input transaction, offered at a falling edge and held until taken.
  // It returns at the falling edge after acceptance; valid is lowered by the
  // next idle cycle or once the last transaction has gone.
  task automatic send_op(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{cmd: cmd, operand_a: a, operand_b: b};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random(int count);
    logic [3:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
    repeat (count) begin
      // Mostly defined opcodes; unused ones now and then.
      cmd = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
      a = $urandom_range(2) == 0 ? edge_operand() : $urandom();
      b = $urandom_range(2) == 0 ? edge_operand() : $urandom();
      // Small divisors keep quotients interesting.
      if ($urandom_range(3) == 0) b = $signed(32'($urandom_range(64))) - 32;
      send_op(cmd, a, b);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: every opcode, the extremes and the special cases.
    send_op(OP_TRUNC,   32'h8000_0000, 32'h0);
    send_op(OP_TRUNC,   32'hFFFF_FFFF, 32'h0);
    send_op(OP_ROUND,   32'h7FFF_FFFF, 32'h0);  // wraps on the added half
    send_op(OP_ROUND,   32'h8000_0000, 32'h0);  // wraps on the subtracted half
    send_op(OP_ROUND,   32'hFFFF_E000, 32'h0);
    send_op(OP_INT2FIX, 32'h7FFF_FFFF, 32'h0);
    send_op(OP_FRAC,    32'd3, 32'd7);
    send_op(OP_FRAC,    32'd5, 32'h0004_0000);  // divisor wraps to zero
    send_op(OP_FRAC,    32'd5, 32'd0);
    send_op(OP_ADD_FI,  32'h7FFF_FFFF, 32'd1);
    send_op(OP_ADD_FF,  32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_op(OP_SUB_FI,  32'h8000_0000, 32'd1);
    send_op(OP_SUB_FF,  32'h8000_0000, 32'h7FFF_FFFF);
    send_op(OP_MUL_FI,  32'h8000_0000, 32'hFFFF_FFFF);
    send_op(OP_MUL_FF,  32'h8000_0000, 32'h8000_0000);
    send_op(OP_MUL_FF,  32'hFFFF_FFFF, 32'h0000_0001);
    send_op(OP_DIV_FI,  32'h8000_0000, 32'hFFFF_FFFF);  // quotient overflow
    send_op(OP_DIV_FI,  32'hFFFF_FFF9, 32'd2);
    send_op(OP_DIV_FI,  32'd1, 32'd0);
    send_op(OP_DIV_FF,  32'h8000_0000, 32'h0000_0001);
    send_op(OP_DIV_FF,  32'h7FFF_FFFF, 32'h8000_0000);
    send_op(OP_DIV_FF,  32'd1, 32'd0);
    send_op(4'd12,      32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(4'd15,      32'h1234_5678, 32'h0);

    // Random part in three idling phases.
    send_random(180);
    send_idle_pct = 85;
    recv_idle_pct = 13;
    send_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(200);
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("fixed_point_17_14_alu_core_test: done, clean");
    end else begin
      $display("fixed_point_17_14_alu_core_test: done, errors");
    end
    $finish;
  end
endmodule

// ===== fixed_point_17_14_alu_core.f =====
design/fpa_pkg.sv
design/fpa_prep.sv
design/fpa_div_cell.sv
design/fixed_point_17_14_alu_core.sv
tb/fixed_point_17_14_alu_checker.sv
tb/fixed_point_17_14_alu_core_test.sv
